FILE: rtl/core/lqe_pkg.sv
// ----------------------------------------------------------------------------
// Link quality estimator package
// Shared widths, constants, microcode types, the control program and the
// averaging arithmetic of the link quality estimator.
// ----------------------------------------------------------------------------
package lqe_pkg;

   // Field widths of the request and response items.
   localparam int ELAPSED_W = 16;
   localparam int PAYLOAD_W = 11;
   localparam int Q16_W     = 17;
   localparam int RTT_W     = 27;
   localparam int GOODPUT_W = 29;
   localparam int FAIL_W    = 16;
   localparam int SHIFT_W   = 4;

   // Averaging arithmetic works on the widest average.
   localparam int ACC_W     = GOODPUT_W;
   localparam int MAX_SHIFT = 8;
   localparam int MIN_SHIFT = 1;
   localparam int BLEND_W   = ACC_W + MAX_SHIFT + 1;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(3);

   // Sample scaling: 1000 ms per second with 8 fraction bits, and
   // 8 bits per byte with 8 fraction bits (a shift by 11).
   localparam int RTT_SCALE = 1000 * 256;
   localparam int GP_SHIFT  = 11;

   // Goodput divider: 34-bit dividend, 16-bit divisor, two quotient bits a step.
   localparam int DIV_W     = 34;
   localparam int DIVISOR_W = 16;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int COUNT_W   = $clog2(DIV_STEPS + 1);

   localparam logic [Q16_W-1:0]  Q16_ONE  = Q16_W'(65536);
   localparam logic [FAIL_W-1:0] FAIL_MAX = {FAIL_W{1'b1}};

   // Datapath operations selected by a control word.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LOAD_RTT,
      OP_DIV_STEP,
      OP_LOAD_GP,
      OP_STORE_GP,
      OP_BLEND_LOSS,
      OP_BLEND_RTT,
      OP_BLEND_GP,
      OP_BLEND_RETRY,
      OP_EMIT
   } op_type;

   // Jump conditions: when true the step counter loads the target,
   // otherwise it advances by one.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_DIV_BUSY,
      COND_OUT_BUSY,
      COND_ALWAYS
   } cond_type;

   localparam int PC_W = 4;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   // Program addresses.
   localparam logic [PC_W-1:0] ADDR_WAIT        = PC_W'(0);
   localparam logic [PC_W-1:0] ADDR_LOAD_RTT    = PC_W'(1);
   localparam logic [PC_W-1:0] ADDR_LOAD_GP     = PC_W'(2);
   localparam logic [PC_W-1:0] ADDR_GP_DIV      = PC_W'(3);
   localparam logic [PC_W-1:0] ADDR_STORE_GP    = PC_W'(4);
   localparam logic [PC_W-1:0] ADDR_BLEND_LOSS  = PC_W'(5);
   localparam logic [PC_W-1:0] ADDR_BLEND_RTT   = PC_W'(6);
   localparam logic [PC_W-1:0] ADDR_BLEND_GP    = PC_W'(7);
   localparam logic [PC_W-1:0] ADDR_BLEND_RETRY = PC_W'(8);
   localparam logic [PC_W-1:0] ADDR_OUT_WAIT    = PC_W'(9);
   localparam logic [PC_W-1:0] ADDR_EMIT        = PC_W'(10);

   // Control store. Unused addresses fall back to the wait step.
   function automatic ctrl_word_type program_word(input logic [PC_W-1:0] addr);
      ctrl_word_type word;
      unique case (addr)
         ADDR_WAIT:        word = '{OP_ACCEPT,      COND_NO_REQ,   ADDR_WAIT};
         ADDR_LOAD_RTT:    word = '{OP_LOAD_RTT,    COND_NEVER,    ADDR_WAIT};
         ADDR_LOAD_GP:     word = '{OP_LOAD_GP,     COND_NEVER,    ADDR_WAIT};
         ADDR_GP_DIV:      word = '{OP_DIV_STEP,    COND_DIV_BUSY, ADDR_GP_DIV};
         ADDR_STORE_GP:    word = '{OP_STORE_GP,    COND_NEVER,    ADDR_WAIT};
         ADDR_BLEND_LOSS:  word = '{OP_BLEND_LOSS,  COND_NEVER,    ADDR_WAIT};
         ADDR_BLEND_RTT:   word = '{OP_BLEND_RTT,   COND_NEVER,    ADDR_WAIT};
         ADDR_BLEND_GP:    word = '{OP_BLEND_GP,    COND_NEVER,    ADDR_WAIT};
         ADDR_BLEND_RETRY: word = '{OP_BLEND_RETRY, COND_NEVER,    ADDR_WAIT};
         ADDR_OUT_WAIT:    word = '{OP_NONE,        COND_OUT_BUSY, ADDR_OUT_WAIT};
         ADDR_EMIT:        word = '{OP_EMIT,        COND_ALWAYS,   ADDR_WAIT};
         default:          word = '{OP_NONE,        COND_ALWAYS,   ADDR_WAIT};
      endcase
      return word;
   endfunction

   // One exponential average update: (prev * (2^k - 1) + sample) >> k.
   // The multiply by 2^k - 1 is a shift and a subtract.
   function automatic logic [ACC_W-1:0] blend(input logic [ACC_W-1:0]   prev,
                                              input logic [ACC_W-1:0]   sample,
                                              input logic [SHIFT_W-1:0] k);
      logic [BLEND_W-1:0] wide;
      wide = (BLEND_W'(prev) << k) - BLEND_W'(prev) + BLEND_W'(sample);
      return ACC_W'(wide >> k);
   endfunction

endpackage

FILE: rtl/core/lqe_req_if.sv
// ----------------------------------------------------------------------------
// Link quality estimator request channel
// Valid/ready channel that carries one transmission outcome per transfer.
// ----------------------------------------------------------------------------
interface lqe_req_if;
   import lqe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ELAPSED_W-1:0] elapsed_ticks;
   logic                 success;
   logic [PAYLOAD_W-1:0] payload_size;

   modport source (output valid, output elapsed_ticks, output success,
                   output payload_size, input ready);
   modport sink   (input valid, input elapsed_ticks, input success,
                   input payload_size, output ready);
endinterface

FILE: rtl/core/lqe_rsp_if.sv
// ----------------------------------------------------------------------------
// Link quality estimator response channel
// Valid/ready channel that carries the updated averages per transfer.
// ----------------------------------------------------------------------------
interface lqe_rsp_if;
   import lqe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [Q16_W-1:0]     loss_average;
   logic [RTT_W-1:0]     rtt_average;
   logic [GOODPUT_W-1:0] goodput_average;
   logic [Q16_W-1:0]     retry_average;
   logic [FAIL_W-1:0]    failure_run;

   modport source (output valid, output loss_average, output rtt_average,
                   output goodput_average, output retry_average,
                   output failure_run, input ready);
   modport sink   (input valid, input loss_average, input rtt_average,
                   input goodput_average, input retry_average,
                   input failure_run, output ready);
endinterface

FILE: rtl/core/link_quality_ewma_estimator.sv
// ----------------------------------------------------------------------------
// Link quality EWMA estimator
// The block takes a new request only after the previous one has been emitted,
// and it stalls while the output register still holds an untaken result; the
// goodput divider takes two quotient bits per step and runs 17 steps.
// Reset is synchronous, active high; it clears the averages, the failure
// count and the control state, and sets the smoothing shift to 3.
// ----------------------------------------------------------------------------
// Microcoded sequencer over a small datapath: a step counter walks a control
// store whose words select one datapath operation and a conditional jump.
// ----------------------------------------------------------------------------
module link_quality_ewma_estimator #(
   parameter int TICKS_PER_SECOND = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [lqe_pkg::SHIFT_W-1:0] csr_write_data,
   lqe_req_if.sink                     req_chan,
   lqe_rsp_if.source                   rsp_chan
);
   import lqe_pkg::*;

   localparam int TickWidth = $clog2(TICKS_PER_SECOND + 1);
   localparam int GpProdW   = PAYLOAD_W + TickWidth;

   // The round-trip time divides by a constant, so it uses a rounded-up
   // reciprocal; a shift that covers the elapsed and the divisor widths
   // makes the truncated product equal to the exact quotient.
   localparam int     RttShift  = ELAPSED_W + TickWidth;
   localparam longint RttRecip  = ((longint'(RTT_SCALE) << RttShift)
                                   + longint'(TICKS_PER_SECOND) - 64'sd1)
                                  / longint'(TICKS_PER_SECOND);
   localparam int     RttRecipW = $clog2(RttRecip + 1);
   localparam int     RttProdW  = ELAPSED_W + RttRecipW;

   // Sequencer state.
   logic [PC_W-1:0]      pc_ff, pc_in;
   ctrl_word_type        ctrl;
   logic                 jump;

   // Configuration.
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [SHIFT_W-1:0]   shift_eff;

   // Latched request.
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 success_ff, success_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;

   // Divider.
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DIV_W-1:0]     quo_step;
   logic [DIVISOR_W-1:0] rem_step;

   // Samples.
   logic [RTT_W-1:0]     rtt_sample_ff, rtt_sample_in;
   logic [GOODPUT_W-1:0] gp_sample_ff, gp_sample_in;
   logic [RttProdW-1:0]  rtt_prod;
   logic [DIV_W-1:0]     rtt_quot;
   logic [GpProdW-1:0]   gp_prod;
   logic [DIV_W-1:0]     gp_dividend;

   // Averages and failure count.
   logic                 primed_ff, primed_in;
   logic [Q16_W-1:0]     loss_acc_ff, loss_acc_in;
   logic [RTT_W-1:0]     rtt_acc_ff, rtt_acc_in;
   logic [GOODPUT_W-1:0] gp_acc_ff, gp_acc_in;
   logic [Q16_W-1:0]     retry_acc_ff, retry_acc_in;
   logic [FAIL_W-1:0]    fail_ff, fail_in;
   logic [ACC_W-1:0]     blend_prev;
   logic [ACC_W-1:0]     blend_sample;
   logic [ACC_W-1:0]     blend_result;

   // Output register.
   logic                 out_valid_ff, out_valid_in;
   logic [Q16_W-1:0]     out_loss_ff, out_loss_in;
   logic [RTT_W-1:0]     out_rtt_ff, out_rtt_in;
   logic [GOODPUT_W-1:0] out_gp_ff, out_gp_in;
   logic [Q16_W-1:0]     out_retry_ff, out_retry_in;
   logic [FAIL_W-1:0]    out_fail_ff, out_fail_in;

   // Fetch the control word and resolve its jump condition.
   assign ctrl = program_word(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:    jump = 1'b0;
         COND_NO_REQ:   jump = !req_chan.valid;
         COND_DIV_BUSY: jump = (count_ff != COUNT_W'(1));
         COND_OUT_BUSY: jump = out_valid_ff && !rsp_chan.ready;
         COND_ALWAYS:   jump = 1'b1;
         default:       jump = 1'b1;
      endcase
      pc_in = jump ? ctrl.target : pc_ff + PC_W'(1);
   end

   // The smoothing shift is clamped to its legal range.
   always_comb begin
      priority if (shift_ff < SHIFT_W'(MIN_SHIFT)) begin
         shift_eff = SHIFT_W'(MIN_SHIFT);
      end else if (shift_ff > SHIFT_W'(MAX_SHIFT)) begin
         shift_eff = SHIFT_W'(MAX_SHIFT);
      end else begin
         shift_eff = shift_ff;
      end
   end

   assign shift_in = csr_write_en ? csr_write_data : shift_ff;

   // Round-trip quotient and goodput dividend.
   assign rtt_prod     = RttProdW'(elapsed_ff) * RttProdW'(RttRecip);
   assign rtt_quot     = DIV_W'(rtt_prod >> RttShift);
   assign gp_prod      = payload_ff * TickWidth'(TICKS_PER_SECOND);
   assign gp_dividend  = DIV_W'({gp_prod, {GP_SHIFT{1'b0}}});

   // Two restoring division steps per cycle.
   always_comb begin
      logic [DIVISOR_W:0] trial;
      quo_step = quo_ff;
      rem_step = rem_ff;
      for (int i = 0; i < 2; i++) begin
         trial    = {rem_step, quo_step[DIV_W-1]};
         quo_step = {quo_step[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial       = trial - {1'b0, divisor_ff};
            quo_step[0] = 1'b1;
         end
         rem_step = trial[DIVISOR_W-1:0];
      end
   end

   // Operand selection for the shared averaging unit.
   always_comb begin
      unique case (ctrl.op)
         OP_BLEND_LOSS: begin
            blend_prev   = ACC_W'(loss_acc_ff);
            blend_sample = success_ff ? '0 : ACC_W'(Q16_ONE);
         end
         OP_BLEND_RTT: begin
            blend_prev   = ACC_W'(rtt_acc_ff);
            blend_sample = ACC_W'(rtt_sample_ff);
         end
         OP_BLEND_GP: begin
            blend_prev   = gp_acc_ff;
            blend_sample = gp_sample_ff;
         end
         OP_BLEND_RETRY: begin
            blend_prev   = ACC_W'(retry_acc_ff);
            blend_sample = (fail_ff != '0) ? ACC_W'(Q16_ONE) : '0;
         end
         default: begin
            blend_prev   = '0;
            blend_sample = '0;
         end
      endcase
      // The first sample loads the average directly.
      blend_result = primed_ff ? blend(blend_prev, blend_sample, shift_eff)
                               : blend_sample;
   end

   // Datapath next values, one operation per control word.
   always_comb begin
      elapsed_in    = elapsed_ff;
      success_in    = success_ff;
      payload_in    = payload_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      count_in      = count_ff;
      rtt_sample_in = rtt_sample_ff;
      gp_sample_in  = gp_sample_ff;
      primed_in     = primed_ff;
      loss_acc_in   = loss_acc_ff;
      rtt_acc_in    = rtt_acc_ff;
      gp_acc_in     = gp_acc_ff;
      retry_acc_in  = retry_acc_ff;
      fail_in       = fail_ff;
      out_loss_in   = out_loss_ff;
      out_rtt_in    = out_rtt_ff;
      out_gp_in     = out_gp_ff;
      out_retry_in  = out_retry_ff;
      out_fail_in   = out_fail_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;

      unique case (ctrl.op)
         OP_ACCEPT: begin
            // An elapsed count of zero counts as one tick.
            if (req_chan.valid) begin
               elapsed_in = (req_chan.elapsed_ticks == '0) ? ELAPSED_W'(1)
                                                           : req_chan.elapsed_ticks;
               success_in = req_chan.success;
               payload_in = req_chan.payload_size;
            end
         end
         OP_LOAD_RTT: begin
            // Keep the round-trip sample, saturated.
            rtt_sample_in = (rtt_quot[DIV_W-1:RTT_W] != '0) ? {RTT_W{1'b1}}
                                                            : rtt_quot[RTT_W-1:0];
         end
         OP_DIV_STEP: begin
            quo_in   = quo_step;
            rem_in   = rem_step;
            count_in = count_ff - COUNT_W'(1);
         end
         OP_LOAD_GP: begin
            quo_in        = gp_dividend;
            rem_in        = '0;
            divisor_in    = DIVISOR_W'(elapsed_ff);
            count_in      = COUNT_W'(DIV_STEPS);
         end
         OP_STORE_GP: begin
            if (!success_ff) begin
               gp_sample_in = '0;
            end else if (quo_ff[DIV_W-1:GOODPUT_W] != '0) begin
               gp_sample_in = {GOODPUT_W{1'b1}};
            end else begin
               gp_sample_in = quo_ff[GOODPUT_W-1:0];
            end
            // Consecutive failure count, saturating.
            if (success_ff) begin
               fail_in = '0;
            end else if (fail_ff != FAIL_MAX) begin
               fail_in = fail_ff + FAIL_W'(1);
            end
         end
         OP_BLEND_LOSS:  loss_acc_in  = blend_result[Q16_W-1:0];
         OP_BLEND_RTT:   rtt_acc_in   = blend_result[RTT_W-1:0];
         OP_BLEND_GP:    gp_acc_in    = blend_result;
         OP_BLEND_RETRY: retry_acc_in = blend_result[Q16_W-1:0];
         OP_EMIT: begin
            primed_in    = 1'b1;
            out_valid_in = 1'b1;
            out_loss_in  = loss_acc_ff;
            out_rtt_in   = rtt_acc_ff;
            out_gp_in    = gp_acc_ff;
            out_retry_in = retry_acc_ff;
            out_fail_in  = fail_ff;
         end
         default: begin
         end
      endcase
   end

   // Control and state registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ADDR_WAIT;
         shift_ff     <= SHIFT_RESET;
         count_ff     <= '0;
         primed_ff    <= 1'b0;
         loss_acc_ff  <= '0;
         rtt_acc_ff   <= '0;
         gp_acc_ff    <= '0;
         retry_acc_ff <= '0;
         fail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         primed_ff    <= primed_in;
         loss_acc_ff  <= loss_acc_in;
         rtt_acc_ff   <= rtt_acc_in;
         gp_acc_ff    <= gp_acc_in;
         retry_acc_ff <= retry_acc_in;
         fail_ff      <= fail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      elapsed_ff    <= elapsed_in;
      success_ff    <= success_in;
      payload_ff    <= payload_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      rtt_sample_ff <= rtt_sample_in;
      gp_sample_ff  <= gp_sample_in;
      out_loss_ff   <= out_loss_in;
      out_rtt_ff    <= out_rtt_in;
      out_gp_ff     <= out_gp_in;
      out_retry_ff  <= out_retry_in;
      out_fail_ff   <= out_fail_in;
   end

   // Channel outputs.
   assign req_chan.ready           = (ctrl.op == OP_ACCEPT);
   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.loss_average    = out_loss_ff;
   assign rsp_chan.rtt_average     = out_rtt_ff;
   assign rsp_chan.goodput_average = out_gp_ff;
   assign rsp_chan.retry_average   = out_retry_ff;
   assign rsp_chan.failure_run     = out_fail_ff;

endmodule

FILE: test/link_quality_ewma_estimator_test.sv
// ----------------------------------------------------------------------------
// Link quality EWMA estimator testbench
// Sends transmission outcomes through the request channel and checks every
// estimate against averages tracked inside the bench. Covers the smoothing
// shifts 0 to 9 and 15 (including the clamped ones), a long output stall, a failure
// streak followed by a success, and random idling on both channels.
// ----------------------------------------------------------------------------
module link_quality_ewma_estimator_test;
   import lqe_pkg::*;

   localparam int TICKS_PER_SECOND = 128;
   localparam int STALL_LIMIT      = 3000;
   localparam int LONG_HOLD        = 400;
   localparam int DRAIN_CYCLES     = 60;

   // One expected estimate, at the widths of the response channel.
   typedef struct packed {
      logic [Q16_W-1:0]     loss;
      logic [RTT_W-1:0]     rtt;
      logic [GOODPUT_W-1:0] goodput;
      logic [Q16_W-1:0]     retry;
      logic [FAIL_W-1:0]    fail_run;
   } estimate_type;

   // Tracks the averages the block should hold and queues the estimates
   // that are still to come out.
   class link_estimate_tracker;
      logic [SHIFT_W-1:0] shift_reg;
      bit                 primed;
      longint unsigned    loss_avg;
      longint unsigned    rtt_avg;
      longint unsigned    goodput_avg;
      longint unsigned    retry_avg;
      longint unsigned    fail_run;
      estimate_type       pending[$];
      int unsigned        mismatches;

      function new();
         shift_reg   = SHIFT_RESET;
         primed      = 1'b0;
         loss_avg    = 0;
         rtt_avg     = 0;
         goodput_avg = 0;
         retry_avg   = 0;
         fail_run    = 0;
         mismatches  = 0;
      endfunction

      function longint unsigned ewma_step(longint unsigned prev,
                                          longint unsigned sample,
                                          int unsigned k);
         return (prev * ((64'd1 << k) - 64'd1) + sample) >> k;
      endfunction

      // Called on every request transfer.
      function void note_outcome(logic [ELAPSED_W-1:0] elapsed, logic ok,
                                 logic [PAYLOAD_W-1:0] bytes);
         longint unsigned ticks;
         longint unsigned size;
         longint unsigned rtt_sample;
         longint unsigned goodput_sample;
         longint unsigned loss_sample;
         longint unsigned retry_sample;
         int unsigned     k;
         estimate_type    est;

         ticks = (elapsed == '0) ? 64'd1 : 64'(elapsed);
         size  = 64'(bytes);

         // Shifts outside the legal range are clamped.
         if (shift_reg < MIN_SHIFT)
            k = MIN_SHIFT;
         else if (shift_reg > MAX_SHIFT)
            k = MAX_SHIFT;
         else
            k = shift_reg;

         rtt_sample = (64'd1000 * ticks * 64'd256) / TICKS_PER_SECOND;
         if (rtt_sample > (64'd1 << RTT_W) - 1)
            rtt_sample = (64'd1 << RTT_W) - 1;

         if (ok) begin
            goodput_sample = (64'd8 * size * TICKS_PER_SECOND * 64'd256) / ticks;
            if (goodput_sample > (64'd1 << GOODPUT_W) - 1)
               goodput_sample = (64'd1 << GOODPUT_W) - 1;
         end else begin
            goodput_sample = 0;
         end

         loss_sample = ok ? 64'd0 : 64'd65536;

         // The failure run saturates instead of wrapping.
         if (ok)
            fail_run = 0;
         else if (fail_run < 65535)
            fail_run++;
         retry_sample = (fail_run > 0) ? 64'd65536 : 64'd0;

         // The very first sample after reset loads the averages directly.
         if (primed) begin
            loss_avg    = ewma_step(loss_avg, loss_sample, k);
            rtt_avg     = ewma_step(rtt_avg, rtt_sample, k);
            goodput_avg = ewma_step(goodput_avg, goodput_sample, k);
            retry_avg   = ewma_step(retry_avg, retry_sample, k);
         end else begin
            loss_avg    = loss_sample;
            rtt_avg     = rtt_sample;
            goodput_avg = goodput_sample;
            retry_avg   = retry_sample;
         end
         primed = 1'b1;

         est.loss     = Q16_W'(loss_avg);
         est.rtt      = RTT_W'(rtt_avg);
         est.goodput  = GOODPUT_W'(goodput_avg);
         est.retry    = Q16_W'(retry_avg);
         est.fail_run = FAIL_W'(fail_run);
         pending.push_back(est);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", field, want, got);
         end
      endfunction

      // Called on every response transfer.
      function void check_estimate(estimate_type got);
         estimate_type want;
         if (pending.size() == 0) begin
            mismatches++;
            $error("estimate transfer with no outcome pending");
            return;
         end
         want = pending.pop_front();
         compare_field("loss_average", 32'(want.loss), 32'(got.loss));
         compare_field("rtt_average", 32'(want.rtt), 32'(got.rtt));
         compare_field("goodput_average", 32'(want.goodput), 32'(got.goodput));
         compare_field("retry_average", 32'(want.retry), 32'(got.retry));
         compare_field("failure_run", 32'(want.fail_run), 32'(got.fail_run));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [SHIFT_W-1:0] csr_write_data = '0;

   lqe_req_if req_chan ();
   lqe_rsp_if rsp_chan ();

   link_estimate_tracker tracker = new();

   bit          idling_on = 1'b1;
   int unsigned holds_requested = 0;
   int unsigned holds_served = 0;
   int unsigned quiet_cycles = 0;
   int unsigned shift_plan[10] = '{1, 8, 0, 15, 9, 2, 5, 7, 4, 6};

   link_quality_ewma_estimator #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   // Observe both channels at the rising edge; check before noting so that
   // a stray estimate can never be matched against a fresh outcome.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            tracker.check_estimate('{rsp_chan.loss_average, rsp_chan.rtt_average,
                                     rsp_chan.goodput_average, rsp_chan.retry_average,
                                     rsp_chan.failure_run});
         if (req_chan.valid && req_chan.ready)
            tracker.note_outcome(req_chan.elapsed_ticks, req_chan.success,
                                 req_chan.payload_size);
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result receiver: random stall bursts, plus a long hold on request.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (holds_served != holds_requested) begin
            holds_served++;
            stall_left = LONG_HOLD - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offer one outcome, possibly after an idle burst, and return at the
   // falling edge after its transfer. The caller drives the next item or
   // lowers valid at that same edge.
   task automatic offer_outcome(input logic [ELAPSED_W-1:0] elapsed, input logic ok,
                                input logic [PAYLOAD_W-1:0] bytes);
      int unsigned gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.elapsed_ticks <= elapsed;
      req_chan.success       <= ok;
      req_chan.payload_size  <= bytes;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic offer_random_outcome(input int unsigned fail_pct);
      logic [ELAPSED_W-1:0] elapsed;
      logic [PAYLOAD_W-1:0] bytes;
      logic                 ok;
      case ($urandom_range(0, 5))
         0:       elapsed = ELAPSED_W'($urandom_range(0, 3));
         1:       elapsed = ELAPSED_W'(65535 - $urandom_range(0, 3));
         default: elapsed = ELAPSED_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
         0:       bytes = '0;
         1:       bytes = '1;
         default: bytes = PAYLOAD_W'($urandom_range(0, 2047));
      endcase
      ok = ($urandom_range(0, 99) >= fail_pct);
      offer_outcome(elapsed, ok, bytes);
   endtask

   // Random outcomes in runs of a dozen, each run with its own failure rate
   // so that failure streaks of varying length occur.
   task automatic run_random_phase(input int unsigned count);
      int unsigned fail_pct;
      fail_pct = 0;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 12 == 0) begin
            case ($urandom_range(0, 3))
               0:       fail_pct = 0;
               1:       fail_pct = 25;
               2:       fail_pct = 60;
               default: fail_pct = 100;
            endcase
         end
         offer_random_outcome(fail_pct);
      end
   endtask

   // Stop offering and wait until every estimate has come out.
   task automatic wait_for_estimates();
      req_chan.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(negedge clock);
   endtask

   task automatic set_smoothing_shift(input logic [SHIFT_W-1:0] value);
      wait_for_estimates();
      @(negedge clock);
      csr_write_en       <= 1'b1;
      csr_write_data     <= value;
      tracker.shift_reg = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      req_chan.valid         = 1'b0;
      req_chan.elapsed_ticks = '0;
      req_chan.success       = 1'b0;
      req_chan.payload_size  = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed outcomes at the reset shift. The first one loads the
      // averages directly; zero elapsed ticks count as one.
      offer_outcome(16'd0, 1'b1, 11'd2047);
      offer_outcome(16'd1, 1'b1, 11'd0);
      offer_outcome(16'd65535, 1'b1, 11'd2047);
      offer_outcome(16'd65535, 1'b0, 11'd2047);
      offer_outcome(16'd0, 1'b0, 11'd0);
      offer_outcome(16'd1, 1'b0, 11'd1);
      offer_outcome(16'd100, 1'b0, 11'd500);
      offer_outcome(16'd2, 1'b1, 11'd1024);
      offer_outcome(16'd0, 1'b1, 11'd0);
      offer_outcome(16'd32768, 1'b1, 11'd1);
      offer_outcome(16'd12345, 1'b0, 11'd2047);
      offer_outcome(16'd128, 1'b1, 11'd1500);
      offer_outcome(16'd1, 1'b1, 11'd2047);

      // Random phases across shifts 0 to 2, 4 to 9 and 15, clamped ones included.
      for (int p = 0; p < 10; p++) begin
         set_smoothing_shift(SHIFT_W'(shift_plan[p]));
         idling_on = ($urandom_range(0, 3) != 0);
         if (p == 2) begin
            // Hold the receiver off while items keep coming, so the block
            // fills up and stalls its request channel.
            idling_on = 1'b0;
            holds_requested++;
            repeat (6) offer_random_outcome(30);
            idling_on = 1'b1;
         end
         run_random_phase(90);
      end

      // A failure streak builds up the failure run, and one success
      // clears it again.
      wait_for_estimates();
      idling_on = 1'b0;
      repeat (24)
         offer_outcome(ELAPSED_W'($urandom_range(0, 65535)), 1'b0,
                       PAYLOAD_W'($urandom_range(0, 2047)));
      offer_outcome(16'd500, 1'b1, 11'd200);

      // Final stretch at the reset shift with no idling on either side.
      set_smoothing_shift(SHIFT_RESET);
      run_random_phase(60);

      wait_for_estimates();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
